// ===== rtl/bounded_list_append_remove_find_top_macros.svh =====
// Assertion macros used by the bounded list datapath (blist_dp).
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef BOUNDED_LIST_APPEND_REMOVE_FIND_TOP_MACROS_SVH
`define BOUNDED_LIST_APPEND_REMOVE_FIND_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BL_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bounded list assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bounded list assertion failed");

`endif

// ===== rtl/blist_pkg.sv =====
// Shared constants, codes and controller/datapath structs for the bounded list.
// No dependencies.
package blist_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam int KIND_W = 2;
   localparam int VALUE_W = 32;
   localparam int STATUS_W = 2;
   localparam int ENTRY_COUNT_W = 5;

   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

   typedef struct packed {
      logic                latch_req;
      logic                start_scan;
      logic                scan_step;
      logic                shift_step;
      logic                append;
      logic                dec;
      logic                set_status;
      logic [STATUS_W-1:0] status_val;
      logic                rsp_load;
   } cmd_type;

   typedef struct packed {
      logic              full;
      logic              match;
      logic              exhausted;
      logic              rsp_free;
      logic [KIND_W-1:0] kind;
   } stat_type;

endpackage

// ===== rtl/blist_req_if.sv =====
// Request channel of the bounded list: operation kind and value.
// Depends on blist_pkg.
interface blist_req_if;
   import blist_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink (input valid, input kind, input value, output ready);
endinterface

// ===== rtl/blist_rsp_if.sv =====
// Response channel of the bounded list: status and entry count.
// Depends on blist_pkg.
interface blist_rsp_if;
   import blist_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [ENTRY_COUNT_W-1:0] entry_count;

   modport source (output valid, output status, output entry_count, input ready);
   modport sink (input valid, input status, input entry_count, output ready);
endinterface

// ===== rtl/blist_ctrl.sv =====
// Controller state machine of the bounded list: sequences append, scan and shift.
// Depends on blist_pkg; drives the datapath through cmd_type only.
module blist_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [blist_pkg::KIND_W-1:0] req_kind,
   output logic                        req_ready,
   input  blist_pkg::stat_type         stat,
   output blist_pkg::cmd_type          cmd
);
   import blist_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status_val = ST_OK;
               state_in = S_RESP;
               if (req_kind == KIND_APPEND) begin
                  if (stat.full) begin
                     cmd.status_val = ST_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end else if (req_kind == KIND_REMOVE || req_kind == KIND_FIND) begin
                  cmd.set_status = 1'b0;
                  cmd.start_scan = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.match) begin
               if (stat.kind == KIND_REMOVE) begin
                  state_in = S_SHIFT;
               end else begin
                  cmd.set_status = 1'b1;
                  cmd.status_val = ST_OK;
                  state_in = S_RESP;
               end
            end else if (stat.exhausted) begin
               cmd.set_status = 1'b1;
               cmd.status_val = ST_MISSING;
               state_in = S_RESP;
            end
         end
         S_SHIFT: begin
            // Each cycle moves one later entry down while the next one is read.
            cmd.shift_step = 1'b1;
            if (stat.exhausted) begin
               cmd.shift_step = 1'b0;
               cmd.dec = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status_val = ST_OK;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            // The response slot may still be occupied; hold in S_RESP until it frees.
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/blist_dp.sv =====
// Datapath of the bounded list: entry memory, count, scan pointers and response register.
// Depends on blist_pkg and the assertion macro header; controlled by blist_ctrl.
`include "bounded_list_append_remove_find_top_macros.svh"

module blist_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  blist_pkg::cmd_type                  cmd,
   output blist_pkg::stat_type                 stat,
   input  logic [blist_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [blist_pkg::VALUE_W-1:0] req_value,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [blist_pkg::STATUS_W-1:0]      rsp_status,
   output logic [blist_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count
);
   import blist_pkg::*;

   logic [VALUE_W-1:0] mem [CAPACITY];

   logic [VALUE_W-1:0]       value_ff;
   logic [KIND_W-1:0]        kind_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic                     valid_ff, valid_in;
   logic [VALUE_W-1:0]       rdata_ff;
   logic [STATUS_W-1:0]      status_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff;

   logic               issue;
   logic               match;
   logic               exhausted;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [VALUE_W-1:0] wr_data;

   assign issue = (cmd.scan_step || cmd.shift_step) && (rd_idx_ff < count_ff);
   assign match = valid_ff && (rdata_ff == value_ff);
   assign exhausted = !valid_ff && (rd_idx_ff >= count_ff);

   assign stat.full = (count_ff >= CNT_W'(CAPACITY));
   assign stat.match = match;
   assign stat.exhausted = exhausted;
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;
   assign stat.kind = kind_ff;

   always_comb begin
      rd_idx_in = rd_idx_ff;
      valid_in = valid_ff;
      idx_in = idx_ff;
      count_in = count_ff;
      if (cmd.start_scan) begin
         rd_idx_in = '0;
         valid_in = 1'b0;
         idx_in = '0;
      end else if (cmd.scan_step || cmd.shift_step) begin
         valid_in = issue;
         if (issue) begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
      end
      // During the scan idx tracks the address in rdata; it freezes on a match
      // and then serves as the write pointer of the shift.
      if (cmd.scan_step && issue && !match) begin
         idx_in = rd_idx_ff;
      end else if (cmd.shift_step && valid_ff) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.append) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.dec) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = count_ff[ADDR_W-1:0];
      wr_data = req_value;
      if (cmd.append) begin
         wr_en = 1'b1;
      end else if (cmd.shift_step && valid_ff) begin
         wr_en = 1'b1;
         wr_addr = idx_ff[ADDR_W-1:0];
         wr_data = rdata_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rdata_ff <= mem[rd_idx_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      idx_ff <= idx_in;
      if (cmd.latch_req) begin
         value_ff <= req_value;
         kind_ff <= req_kind;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_val;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff <= ENTRY_COUNT_W'(count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   `BL_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `BL_ASSERT_IMPL(a_shift_in_range, cmd.shift_step && valid_ff, (idx_ff + 1'b1) < count_ff)
   `BL_ASSERT_IMPL(a_rsp_slot_free, cmd.rsp_load, !rsp_valid_ff || rsp_ready)
   `BL_ASSERT_NEXT(a_append_grows, cmd.append, count_ff == $past(count_ff) + 1'b1)

endmodule

// ===== rtl/bounded_list_append_remove_find_top.sv =====
// Bounded ordered list of signed 32-bit values with append, remove and find.
//
// Channels: req_if carries kind (0 append, 1 remove first match, 2 find) and
// value; rsp_if returns status (0 done or found, 1 list full, 2 not found) and
// entry_count, the number of entries held after the operation. Both use a
// valid/ready handshake; a request or response moves when both are high.
// One request is worked at a time and gives exactly one response.
// The first edge that can take a response is also the first edge that can
// accept the next request. A find or a remove scans the entries in order, and
// a remove that hits then shifts the later entries down. The entry memory has
// one read and one write port, so a scan or a shift handles one entry per cycle.
// A finished response sits in an output register; the next request is taken
// while it waits, but that request's response is held back until the slot
// has been taken, so a stalled receiver eventually stalls the request side.
// Synchronous reset empties the list and drops any pending response; entry
// storage itself is not cleared.
// Depends on blist_pkg, blist_req_if, blist_rsp_if, blist_ctrl and blist_dp.
module bounded_list_append_remove_find_top (
   input logic         clock,
   input logic         reset,
   blist_req_if.sink   req_if,
   blist_rsp_if.source rsp_if
);
   import blist_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   blist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (req_if.kind),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   blist_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_kind        (req_if.kind),
      .req_value       (req_if.value),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_status      (rsp_if.status),
      .rsp_entry_count (rsp_if.entry_count)
   );

endmodule

// ===== bench/blist_result_check.sv =====
// Checker for the bounded list: watches the request and response channels, keeps its own
// copy of the list and compares every response with the result it predicts.
// Depends on blist_pkg, blist_req_if and blist_rsp_if.
module blist_result_check (
   input  logic  clock,
   input  logic  reset,
   blist_req_if  req_mon,
   blist_rsp_if  rsp_mon,
   output int    mismatches,
   output int    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import blist_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } list_result_type;

   logic signed [VALUE_W-1:0] held_values[$];
   list_result_type           expected_results[$];

   // Applies one request to the local copy of the list and returns its response.
   function automatic list_result_type apply_request(logic [KIND_W-1:0] kind,
                                                     logic signed [VALUE_W-1:0] value);
      list_result_type result;
      int              hit;
      result.status = ST_OK;
      hit = -1;
      foreach (held_values[i]) begin
         if (hit < 0 && held_values[i] == value) hit = i;
      end
      case (kind)
         KIND_APPEND: begin
            if (held_values.size() >= CAPACITY) result.status = ST_FULL;
            else held_values.insert(held_values.size(), value);
         end
         KIND_REMOVE: begin
            if (hit < 0) result.status = ST_MISSING;
            else held_values.delete(hit);
         end
         KIND_FIND: begin
            if (hit < 0) result.status = ST_MISSING;
         end
         default: ;
      endcase
      result.entry_count = ENTRY_COUNT_W'(held_values.size());
      return result;
   endfunction

   task automatic flag_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         held_values.delete();
         expected_results.delete();
         mismatches = 0;
         pending <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               flag_mismatch($sformatf("response with no request waiting (status %0d count %0d)",
                                       rsp_mon.status, rsp_mon.entry_count));
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.status !== want.status)
                  flag_mismatch($sformatf("status %0d, predicted %0d",
                                          rsp_mon.status, want.status));
               if (rsp_mon.entry_count !== want.entry_count)
                  flag_mismatch($sformatf("entry_count %0d, predicted %0d",
                                          rsp_mon.entry_count, want.entry_count));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            want = apply_request(req_mon.kind, req_mon.value);
            expected_results.insert(expected_results.size(), want);
         end
         pending <= expected_results.size();
      end
   end

endmodule

// ===== bench/testbench.sv =====
// Top of the bounded list testbench: clock, reset, request stimulus, response back-pressure,
// watchdog and verdict. Depends on blist_pkg, the channel interfaces, blist_result_check
// and bounded_list_append_remove_find_top.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import blist_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 3000;
   localparam int TAIL_CYCLES = 40;

   typedef enum logic [2:0] {
      PH_DIRECTED,
      PH_RECEIVER_SLOW,
      PH_SENDER_SLOW,
      PH_BACKPRESSURE,
      PH_FULL_RATE
   } phase_type;

   logic        clock = 1'b0;
   logic        reset;
   phase_type   phase;
   int unsigned tx_idle_pct;
   int          mismatches;
   int          pending;
   int          quiet_cycles;
   logic signed [VALUE_W-1:0] value_pool[8];

   blist_req_if req_ch();
   blist_rsp_if rsp_ch();

   bounded_list_append_remove_find_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   blist_result_check result_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always #6 clock = ~clock;

   function automatic int unsigned idle_pct(phase_type ph, bit receiver);
      case (ph)
         PH_DIRECTED, PH_RECEIVER_SLOW: return receiver ? 50 : 8;
         PH_SENDER_SLOW:                return receiver ? 8 : 50;
         default:                       return 0;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind(int unsigned append_pct);
      if ($urandom_range(99) < 3) return KIND_UNUSED;
      if ($urandom_range(99) < append_pct) return KIND_APPEND;
      return $urandom_range(1) ? KIND_REMOVE : KIND_FIND;
   endfunction

   // Mostly values from a small pool, so removes and finds hit entries that are held.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(3) == 0) return $urandom;
      return value_pool[$urandom_range(7)];
   endfunction

   task automatic send_request(logic [KIND_W-1:0] kind, logic signed [VALUE_W-1:0] value);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.value <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Random requests in bursts that lean toward growing, shrinking or holding the list.
   task automatic run_phase(phase_type ph, int unsigned n_items);
      int unsigned append_pct;
      int unsigned i;
      phase <= ph;
      tx_idle_pct = idle_pct(ph, 1'b0);
      append_pct = 50;
      for (i = 0; i < n_items; i++) begin
         if (i % 32 == 0) begin
            case ($urandom_range(2))
               0:       append_pct = 15;
               1:       append_pct = 50;
               default: append_pct = 85;
            endcase
         end
         send_request(pick_kind(append_pct), pick_value());
      end
      drain_responses();
   endtask

   // Response side: random stalls, plus one long hold-off when the back-pressure phase begins.
   initial begin
      bit held_off;
      held_off = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase == PH_BACKPRESSURE && !held_off) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct(phase, 1'b1));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ns: no request or response moved for %0d cycles", $time, QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int i;
      reset <= 1'b1;
      phase <= PH_DIRECTED;
      req_ch.valid <= 1'b0;
      req_ch.kind  <= KIND_APPEND;
      req_ch.value <= '0;
      value_pool[0] = VALUE_MIN;
      value_pool[1] = VALUE_MAX;
      value_pool[2] = '0;
      value_pool[3] = -1;
      for (i = 4; i < 8; i++) value_pool[i] = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list, extremes, duplicates, the undefined kind, then a full list.
      tx_idle_pct = idle_pct(PH_DIRECTED, 1'b0);
      send_request(KIND_FIND, 32'sd5);
      send_request(KIND_REMOVE, 32'sd5);
      send_request(KIND_APPEND, VALUE_MIN);
      send_request(KIND_APPEND, VALUE_MAX);
      send_request(KIND_APPEND, 32'sd5);
      send_request(KIND_APPEND, -32'sd1);
      send_request(KIND_APPEND, 32'sd5);
      send_request(KIND_FIND, VALUE_MIN);
      send_request(KIND_FIND, 32'sd7);
      send_request(KIND_REMOVE, 32'sd5);
      send_request(KIND_FIND, 32'sd5);
      send_request(KIND_UNUSED, VALUE_MAX);
      for (i = 0; i < 12; i++) send_request(KIND_APPEND, $urandom);
      send_request(KIND_APPEND, VALUE_MAX);
      drain_responses();

      run_phase(PH_RECEIVER_SLOW, 600);
      run_phase(PH_SENDER_SLOW, 600);
      run_phase(PH_BACKPRESSURE, 60);
      run_phase(PH_FULL_RATE, 490);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== bounded_list_append_remove_find_top.f =====
+incdir+rtl
rtl/blist_pkg.sv
rtl/blist_req_if.sv
rtl/blist_rsp_if.sv
rtl/blist_ctrl.sv
rtl/blist_dp.sv
rtl/bounded_list_append_remove_find_top.sv
bench/blist_result_check.sv
bench/testbench.sv
